[hw/rtl/rfce_pkg.sv]
// Package for the rectangle fill and copy engine.
// Holds the command codes, configuration register indexes, field widths and the
// controller state type. It depends on nothing.
package rfce_pkg;

    localparam int COORD_W = 6;
    localparam int LEN_W = 7;
    localparam int PIXEL_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [2:0] OP_NOP = 3'd0;
    localparam logic [2:0] OP_FILL = 3'd1;
    localparam logic [2:0] OP_COPY = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [LEN_W-1:0] FRAME_SIZE_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SETUP,
        ST_FILL,
        ST_COPY,
        ST_DRAIN,
        ST_PIX_WR,
        ST_PIX_RD,
        ST_RD_WAIT,
        ST_RESP
    } state_t;

endpackage

[hw/rtl/rfce_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// It depends on nothing.
module rfce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

[hw/rtl/rect_fill_and_copy_engine.sv]
// Top level of the rectangle fill and copy engine over an internal frame store.
// Depends on rfce_pkg for codes and types and on rfce_ram for the frame store.
//
// Usage:
// Commands arrive as transactions on the in channel (in_valid, in_ready) and each
// produces exactly one result transaction on the out channel (out_valid, out_ready)
// carrying status and read_data. The cfg channel writes frame_width (index 0) and
// frame_height (index 1); cfg_ready is always high and other indexes are ignored.
// One command is worked on at a time. Fill and copy work on the clipped rectangle:
// the store has one write and one read port, so fill writes one pixel a cycle and
// copy streams one read and one write a cycle. A new command is accepted as soon as
// the previous one has moved its result into the output register, even if the
// receiver has not yet taken that result. When the receiver stalls, the next command
// finishes its work and then waits until the output register is free. Reset empties
// the output register, returns to idle and sets both frame registers to 64; the
// frame store is not cleared and its contents are undefined until written.
module rect_fill_and_copy_engine #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        operation,
    input  logic [rfce_pkg::COORD_W-1:0]      dst_x,
    input  logic [rfce_pkg::COORD_W-1:0]      dst_y,
    input  logic [rfce_pkg::COORD_W-1:0]      src_x,
    input  logic [rfce_pkg::COORD_W-1:0]      src_y,
    input  logic [rfce_pkg::LEN_W-1:0]        rect_w,
    input  logic [rfce_pkg::LEN_W-1:0]        rect_h,
    input  logic [rfce_pkg::PIXEL_W-1:0]      colour,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic [rfce_pkg::PIXEL_W-1:0]      read_data,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rfce_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rfce_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = rfce_pkg::LEN_W;
    localparam int PW = rfce_pkg::PIXEL_W;
    localparam logic [LW-1:0] CAP_W = LW'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
    localparam logic [LW-1:0] CAP_H = LW'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

    function automatic logic [LW-1:0] clip_len(input logic [LW-1:0] pos,
                                               input logic [LW-1:0] len,
                                               input logic [LW-1:0] lim);
        logic [LW-1:0] room;
        room = lim - pos;
        if (pos >= lim)
        begin
            return '0;
        end
        return (len > room) ? room : len;
    endfunction

    rfce_pkg::state_t state_reg, state_next;

    logic [LW-1:0] frame_width_reg, frame_height_reg;

    logic [2:0]                   op_reg;
    logic [rfce_pkg::COORD_W-1:0] dx_reg, dy_reg, sx_reg, sy_reg;
    logic [LW-1:0]                w_reg, h_reg;
    logic [PW-1:0]                colour_reg;

    logic [LW-1:0] wc_reg, wc_next, hc_reg, hc_next;
    logic          rev_reg, rev_next;
    logic [AW-1:0] dst_base_reg, dst_base_next, src_base_reg, src_base_next;
    logic [LW-1:0] col_reg, col_next, row_reg, row_next;
    logic          res_status_reg, res_status_next;
    logic [PW-1:0] res_data_reg, res_data_next;

    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          fwd_hit_reg, fwd_hit_next;
    logic [PW-1:0] fwd_data_reg, fwd_data_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_status_reg;
    logic [PW-1:0] out_data_reg;
    logic          out_load;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [PW-1:0] wr_data, ram_rd_data;

    logic [LW-1:0] lim_w, lim_h, xoff, dst_row, src_row;
    logic          pix_in_store, last_col, last_px, known_op;

    rfce_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign lim_w = (frame_width_reg > CAP_W) ? CAP_W : frame_width_reg;
    assign lim_h = (frame_height_reg > CAP_H) ? CAP_H : frame_height_reg;
    assign pix_in_store = (32'(dx_reg) < MAX_WIDTH) && (32'(dy_reg) < MAX_HEIGHT);
    assign xoff = rev_reg ? (wc_reg - LW'(1) - col_reg) : col_reg;
    assign last_col = (col_reg == wc_reg - LW'(1));
    assign last_px = last_col && (row_reg == hc_reg - LW'(1));
    assign dst_row = LW'(dy_reg) + (rev_reg ? hc_reg - LW'(1) : '0);
    assign src_row = LW'(sy_reg) + (rev_reg ? hc_reg - LW'(1) : '0);
    assign known_op = (op_reg == rfce_pkg::OP_NOP) || (op_reg == rfce_pkg::OP_FILL) ||
                      (op_reg == rfce_pkg::OP_COPY) || (op_reg == rfce_pkg::OP_WRITE) ||
                      (op_reg == rfce_pkg::OP_READ);

    assign in_ready = (state_reg == rfce_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign read_data = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        wc_next = wc_reg;
        hc_next = hc_reg;
        rev_next = rev_reg;
        dst_base_next = dst_base_reg;
        src_base_next = src_base_reg;
        col_next = col_reg;
        row_next = row_reg;
        res_status_next = res_status_reg;
        res_data_next = res_data_reg;
        pend_next = 1'b0;
        pend_addr_next = pend_addr_reg;
        wr_en = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
        rd_en = 1'b0;
        rd_addr = src_base_reg + AW'(xoff);
        out_load = 1'b0;

        unique case (state_reg)
            rfce_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rfce_pkg::ST_CLIP;
                end
            end
            rfce_pkg::ST_CLIP:
            begin
                if (op_reg == rfce_pkg::OP_COPY)
                begin
                    wc_next = clip_len(LW'(dx_reg), clip_len(LW'(sx_reg), w_reg, lim_w), lim_w);
                    hc_next = clip_len(LW'(dy_reg), clip_len(LW'(sy_reg), h_reg, lim_h), lim_h);
                    rev_next = (dy_reg > sy_reg) || ((dy_reg == sy_reg) && (dx_reg > sx_reg));
                end
                else
                begin
                    wc_next = clip_len(LW'(dx_reg), w_reg, lim_w);
                    hc_next = clip_len(LW'(dy_reg), h_reg, lim_h);
                    rev_next = 1'b0;
                end
                state_next = rfce_pkg::ST_SETUP;
            end
            rfce_pkg::ST_SETUP:
            begin
                dst_base_next = AW'(dst_row) * ROW_STEP + AW'(dx_reg);
                src_base_next = AW'(src_row) * ROW_STEP + AW'(sx_reg);
                col_next = '0;
                row_next = '0;
                res_status_next = !known_op;
                res_data_next = '0;
                unique case (op_reg)
                    rfce_pkg::OP_FILL:
                    begin
                        state_next = (wc_reg == '0 || hc_reg == '0) ? rfce_pkg::ST_RESP
                                                                    : rfce_pkg::ST_FILL;
                    end
                    rfce_pkg::OP_COPY:
                    begin
                        state_next = (wc_reg == '0 || hc_reg == '0) ? rfce_pkg::ST_RESP
                                                                    : rfce_pkg::ST_COPY;
                    end
                    rfce_pkg::OP_WRITE:
                    begin
                        state_next = rfce_pkg::ST_PIX_WR;
                    end
                    rfce_pkg::OP_READ:
                    begin
                        state_next = rfce_pkg::ST_PIX_RD;
                    end
                    default:
                    begin
                        state_next = rfce_pkg::ST_RESP;
                    end
                endcase
            end
            rfce_pkg::ST_FILL, rfce_pkg::ST_COPY:
            begin
                if (state_reg == rfce_pkg::ST_FILL)
                begin
                    wr_en = 1'b1;
                    wr_addr = dst_base_reg + AW'(xoff);
                    wr_data = colour_reg;
                end
                else
                begin
                    rd_en = 1'b1;
                    pend_next = 1'b1;
                    pend_addr_next = dst_base_reg + AW'(xoff);
                    wr_en = pend_reg;
                end
                if (last_col)
                begin
                    col_next = '0;
                    row_next = row_reg + LW'(1);
                    dst_base_next = rev_reg ? dst_base_reg - ROW_STEP : dst_base_reg + ROW_STEP;
                    src_base_next = rev_reg ? src_base_reg - ROW_STEP : src_base_reg + ROW_STEP;
                end
                else
                begin
                    col_next = col_reg + LW'(1);
                end
                if (last_px)
                begin
                    state_next = (state_reg == rfce_pkg::ST_FILL) ? rfce_pkg::ST_RESP
                                                                  : rfce_pkg::ST_DRAIN;
                end
            end
            rfce_pkg::ST_DRAIN:
            begin
                wr_en = pend_reg;
                state_next = rfce_pkg::ST_RESP;
            end
            rfce_pkg::ST_PIX_WR:
            begin
                wr_en = pix_in_store;
                wr_addr = dst_base_reg;
                wr_data = colour_reg;
                state_next = rfce_pkg::ST_RESP;
            end
            rfce_pkg::ST_PIX_RD:
            begin
                rd_en = pix_in_store;
                rd_addr = dst_base_reg;
                state_next = rfce_pkg::ST_RD_WAIT;
            end
            rfce_pkg::ST_RD_WAIT:
            begin
                res_data_next = pix_in_store ? ram_rd_data : '0;
                state_next = rfce_pkg::ST_RESP;
            end
            rfce_pkg::ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    state_next = rfce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfce_pkg::ST_IDLE;
            end
        endcase

        fwd_hit_next = rd_en && wr_en && (rd_addr == wr_addr);
        fwd_data_next = wr_data;
        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfce_pkg::ST_IDLE;
            frame_width_reg <= rfce_pkg::FRAME_SIZE_RESET;
            frame_height_reg <= rfce_pkg::FRAME_SIZE_RESET;
            pend_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            fwd_hit_reg <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rfce_pkg::REG_FRAME_WIDTH)
                begin
                    frame_width_reg <= cfg_data;
                end
                else if (cfg_index == rfce_pkg::REG_FRAME_HEIGHT)
                begin
                    frame_height_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= operation;
            dx_reg <= dst_x;
            dy_reg <= dst_y;
            sx_reg <= src_x;
            sy_reg <= src_y;
            w_reg <= rect_w;
            h_reg <= rect_h;
            colour_reg <= colour;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg <= res_data_reg;
        end
        wc_reg <= wc_next;
        hc_reg <= hc_next;
        rev_reg <= rev_next;
        dst_base_reg <= dst_base_next;
        src_base_reg <= src_base_next;
        col_reg <= col_next;
        row_reg <= row_next;
        res_status_reg <= res_status_next;
        res_data_reg <= res_data_next;
        pend_addr_reg <= pend_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for rect_fill_and_copy_engine.
// A scoreboard class keeps a shadow frame store and predicts every result transaction.
// Depends on rfce_pkg and the engine RTL.
module testbench;

    localparam int STORE_W = 64;
    localparam int STORE_H = 64;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 136;
    localparam longint TIMEOUT_TICKS = 64'd400_000_000;

    localparam logic [2:0] OP_LAST = 3'd7;
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;
    localparam logic [rfce_pkg::CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [rfce_pkg::CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [2:0]                   op;
        logic [rfce_pkg::COORD_W-1:0] dst_x;
        logic [rfce_pkg::COORD_W-1:0] dst_y;
        logic [rfce_pkg::COORD_W-1:0] src_x;
        logic [rfce_pkg::COORD_W-1:0] src_y;
        logic [rfce_pkg::LEN_W-1:0]   rect_w;
        logic [rfce_pkg::LEN_W-1:0]   rect_h;
        logic [rfce_pkg::PIXEL_W-1:0] colour;
    } command_t;

    typedef struct packed {
        logic                         status;
        logic [rfce_pkg::PIXEL_W-1:0] read_data;
    } result_t;

    class engine_scoreboard;
        logic [rfce_pkg::PIXEL_W-1:0] shadow_pixels [STORE_W*STORE_H];
        int unsigned frame_w;
        int unsigned frame_h;
        result_t expected_results [$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            frame_w = 64;
            frame_h = 64;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [rfce_pkg::CFG_INDEX_W-1:0] index,
                                   logic [rfce_pkg::CFG_DATA_W-1:0] value);
            if (index == rfce_pkg::REG_FRAME_WIDTH)
                frame_w = 32'(value);
            else if (index == rfce_pkg::REG_FRAME_HEIGHT)
                frame_h = 32'(value);
        endfunction

        function int unsigned clip_length(int unsigned pos, int unsigned len, int unsigned lim);
            if (pos >= lim)
                return 0;
            return (len > lim - pos) ? lim - pos : len;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_command(command_t c);
            int unsigned fw, fh, w, h, d, s, dx, dy, sx, sy;
            int i, j;
            result_t r;
            fw = (frame_w > STORE_W) ? STORE_W : frame_w;
            fh = (frame_h > STORE_H) ? STORE_H : frame_h;
            dx = 32'(c.dst_x);
            dy = 32'(c.dst_y);
            sx = 32'(c.src_x);
            sy = 32'(c.src_y);
            r.status = STATUS_DONE;
            r.read_data = '0;
            case (c.op)
                rfce_pkg::OP_NOP: ;
                rfce_pkg::OP_FILL:
                begin
                    w = clip_length(dx, 32'(c.rect_w), fw);
                    h = clip_length(dy, 32'(c.rect_h), fh);
                    for (j = 0; j < int'(h); j++)
                        for (i = 0; i < int'(w); i++)
                            shadow_pixels[(dy + j) * STORE_W + dx + i] = c.colour;
                end
                rfce_pkg::OP_COPY:
                begin
                    w = clip_length(sx, 32'(c.rect_w), fw);
                    w = clip_length(dx, w, fw);
                    h = clip_length(sy, 32'(c.rect_h), fh);
                    h = clip_length(dy, h, fh);
                    d = dy * STORE_W + dx;
                    s = sy * STORE_W + sx;
                    if (d > s)
                    begin
                        for (j = int'(h) - 1; j >= 0; j--)
                            for (i = int'(w) - 1; i >= 0; i--)
                                shadow_pixels[d + j * STORE_W + i] =
                                    shadow_pixels[s + j * STORE_W + i];
                    end
                    else
                    begin
                        for (j = 0; j < int'(h); j++)
                            for (i = 0; i < int'(w); i++)
                                shadow_pixels[d + j * STORE_W + i] =
                                    shadow_pixels[s + j * STORE_W + i];
                    end
                end
                rfce_pkg::OP_WRITE:
                begin
                    if (dx < STORE_W && dy < STORE_H)
                        shadow_pixels[dy * STORE_W + dx] = c.colour;
                end
                rfce_pkg::OP_READ:
                begin
                    if (dx < STORE_W && dy < STORE_H)
                        r.read_data = shadow_pixels[dy * STORE_W + dx];
                end
                default: r.status = STATUS_REJECTED;
            endcase
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
            errors++;
        endtask

        task check_result(logic got_status, logic [rfce_pkg::PIXEL_W-1:0] got_data);
            result_t r;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction, status %0b read_data %08h",
                                          got_status, got_data));
                return;
            end
            r = expected_results.pop_front();
            if (got_status !== r.status)
                report_mismatch($sformatf("status %0b, expected %0b", got_status, r.status));
            if (got_data !== r.read_data)
                report_mismatch($sformatf("read_data %08h, expected %08h", got_data,
                                          r.read_data));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] operation;
    logic [rfce_pkg::COORD_W-1:0] dst_x;
    logic [rfce_pkg::COORD_W-1:0] dst_y;
    logic [rfce_pkg::COORD_W-1:0] src_x;
    logic [rfce_pkg::COORD_W-1:0] src_y;
    logic [rfce_pkg::LEN_W-1:0] rect_w;
    logic [rfce_pkg::LEN_W-1:0] rect_h;
    logic [rfce_pkg::PIXEL_W-1:0] colour;
    logic out_valid;
    logic out_ready;
    logic status;
    logic [rfce_pkg::PIXEL_W-1:0] read_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [rfce_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rfce_pkg::CFG_DATA_W-1:0] cfg_data;

    engine_scoreboard sb;
    logic quiet;
    int idle_odds;
    int stall_odds;

    rect_fill_and_copy_engine #(
        .MAX_WIDTH(STORE_W),
        .MAX_HEIGHT(STORE_H)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .dst_x(dst_x),
        .dst_y(dst_y),
        .src_x(src_x),
        .src_y(src_y),
        .rect_w(rect_w),
        .rect_h(rect_h),
        .colour(colour),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .read_data(read_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, read_data);
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_TICKS);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_command(command_t c);
        @(negedge clk);
        if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= c.op;
        dst_x <= c.dst_x;
        dst_y <= c.dst_y;
        src_x <= c.src_x;
        src_y <= c.src_y;
        rect_w <= c.rect_w;
        rect_h <= c.rect_h;
        colour <= c.colour;
        do @(posedge clk); while (!in_ready);
        sb.note_command(c);
    endtask

    task automatic issue(logic [2:0] op, int dx, int dy, int sx, int sy, int w, int h,
                         logic [rfce_pkg::PIXEL_W-1:0] pixel);
        command_t c;
        c.op = op;
        c.dst_x = rfce_pkg::COORD_W'(dx);
        c.dst_y = rfce_pkg::COORD_W'(dy);
        c.src_x = rfce_pkg::COORD_W'(sx);
        c.src_y = rfce_pkg::COORD_W'(sy);
        c.rect_w = rfce_pkg::LEN_W'(w);
        c.rect_h = rfce_pkg::LEN_W'(h);
        c.colour = pixel;
        send_command(c);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(logic [rfce_pkg::CFG_INDEX_W-1:0] index,
                                  logic [rfce_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [rfce_pkg::COORD_W-1:0] pick_coord(int unsigned lim);
        int unsigned span;
        span = (lim > STORE_W) ? STORE_W : lim;
        if (span != 0 && $urandom_range(0, 9) < 7)
            return rfce_pkg::COORD_W'($urandom_range(0, span - 1));
        return rfce_pkg::COORD_W'($urandom_range(0, STORE_W - 1));
    endfunction

    function automatic logic [rfce_pkg::LEN_W-1:0] pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return rfce_pkg::LEN_W'(64);
        if (roll < 4)
            return rfce_pkg::LEN_W'($urandom_range(25, 64));
        if (roll < 14)
            return rfce_pkg::LEN_W'($urandom_range(0, 24));
        return rfce_pkg::LEN_W'($urandom_range(0, 8));
    endfunction

    function automatic logic [rfce_pkg::CFG_DATA_W-1:0] pick_frame_size();
        case ($urandom_range(0, 7))
            0: return rfce_pkg::CFG_DATA_W'(0);
            1: return rfce_pkg::CFG_DATA_W'(1);
            2: return rfce_pkg::CFG_DATA_W'(64);
            3: return rfce_pkg::CFG_DATA_W'(127);
            4: return rfce_pkg::CFG_DATA_W'($urandom_range(65, 127));
            default: return rfce_pkg::CFG_DATA_W'($urandom_range(2, 63));
        endcase
    endfunction

    function automatic command_t make_random_command();
        command_t c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 24)
            c.op = rfce_pkg::OP_FILL;
        else if (roll < 52)
            c.op = rfce_pkg::OP_COPY;
        else if (roll < 66)
            c.op = rfce_pkg::OP_WRITE;
        else if (roll < 86)
            c.op = rfce_pkg::OP_READ;
        else if (roll < 91)
            c.op = rfce_pkg::OP_NOP;
        else
            c.op = 3'($urandom_range(int'(rfce_pkg::OP_READ) + 1, int'(OP_LAST)));
        c.dst_x = pick_coord(sb.frame_w);
        c.dst_y = pick_coord(sb.frame_h);
        c.src_x = pick_coord(sb.frame_w);
        c.src_y = pick_coord(sb.frame_h);
        c.rect_w = pick_len();
        c.rect_h = pick_len();
        case ($urandom_range(0, 9))
            0: c.colour = '0;
            1: c.colour = '1;
            default: c.colour = $urandom;
        endcase
        return c;
    endfunction

    initial
    begin
        logic [rfce_pkg::CFG_DATA_W-1:0] fw, fh;
        int phase;
        sb = new();
        quiet = 1'b0;
        idle_odds = 4;
        stall_odds = 4;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = rfce_pkg::OP_NOP;
        dst_x = '0;
        dst_y = '0;
        src_x = '0;
        src_y = '0;
        rect_w = '0;
        rect_h = '0;
        colour = '0;
        cfg_valid = 1'b0;
        cfg_index = rfce_pkg::REG_FRAME_WIDTH;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_register(REG_UNUSED_A, rfce_pkg::CFG_DATA_W'(5));
        write_register(rfce_pkg::REG_FRAME_WIDTH, rfce_pkg::CFG_DATA_W'(64));
        write_register(rfce_pkg::REG_FRAME_HEIGHT, rfce_pkg::CFG_DATA_W'(64));

        issue(rfce_pkg::OP_FILL, 0, 0, 0, 0, 64, 64, 32'hFFFF_FFFF);
        issue(rfce_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0, 32'h0000_0000);
        issue(rfce_pkg::OP_WRITE, 63, 63, 63, 63, 64, 64, 32'h1234_5678);
        issue(rfce_pkg::OP_WRITE, 63, 0, 0, 63, 1, 1, 32'h8000_0001);
        issue(rfce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 32'h0);
        issue(rfce_pkg::OP_READ, 63, 63, 0, 0, 0, 0, 32'h0);
        issue(rfce_pkg::OP_READ, 63, 0, 0, 0, 0, 0, 32'h0);
        issue(rfce_pkg::OP_FILL, 2, 3, 0, 0, 0, 9, 32'h5555_5555);
        issue(rfce_pkg::OP_FILL, 60, 58, 0, 0, 64, 64, 32'hA5A5_A5A5);
        issue(rfce_pkg::OP_COPY, 1, 1, 0, 0, 10, 10, 32'h0);
        issue(rfce_pkg::OP_COPY, 3, 4, 5, 5, 20, 3, 32'h0);
        issue(rfce_pkg::OP_COPY, 10, 50, 40, 2, 64, 64, 32'h0);
        issue(rfce_pkg::OP_COPY, 0, 0, 0, 0, 64, 64, 32'h0);
        issue(rfce_pkg::OP_READ, 10, 10, 0, 0, 0, 0, 32'h0);
        issue(rfce_pkg::OP_READ, 10, 50, 0, 0, 0, 0, 32'h0);
        issue(rfce_pkg::OP_NOP, 63, 63, 63, 63, 64, 64, 32'hFFFF_FFFF);
        issue(rfce_pkg::OP_READ + 3'd1, 7, 9, 11, 13, 5, 6, 32'hDEAD_BEEF);
        issue(OP_LAST - 3'd1, 63, 0, 63, 0, 64, 0, 32'h0);
        issue(OP_LAST, 0, 63, 0, 63, 0, 64, 32'hFFFF_FFFF);

        drain_results();
        write_register(rfce_pkg::REG_FRAME_WIDTH, rfce_pkg::CFG_DATA_W'(20));
        write_register(rfce_pkg::REG_FRAME_HEIGHT, rfce_pkg::CFG_DATA_W'(37));
        issue(rfce_pkg::OP_FILL, 20, 5, 0, 0, 4, 4, 32'h0F0F_0F0F);
        issue(rfce_pkg::OP_COPY, 0, 0, 25, 0, 5, 5, 32'h0);
        issue(rfce_pkg::OP_WRITE, 50, 50, 0, 0, 0, 0, 32'hC3C3_3C3C);
        issue(rfce_pkg::OP_READ, 50, 50, 0, 0, 0, 0, 32'h0);
        issue(rfce_pkg::OP_READ, 61, 60, 0, 0, 0, 0, 32'h0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            if (phase == PHASES - 1)
                quiet = 1'b1;
            write_register(phase[0] ? REG_UNUSED_A : REG_UNUSED_B,
                           rfce_pkg::CFG_DATA_W'($urandom));
            case (phase)
                0:
                begin
                    fw = rfce_pkg::CFG_DATA_W'(0);
                    fh = rfce_pkg::CFG_DATA_W'(64);
                end
                1:
                begin
                    fw = rfce_pkg::CFG_DATA_W'(127);
                    fh = rfce_pkg::CFG_DATA_W'(127);
                end
                2:
                begin
                    fw = rfce_pkg::CFG_DATA_W'(1);
                    fh = rfce_pkg::CFG_DATA_W'(1);
                end
                3:
                begin
                    fw = rfce_pkg::CFG_DATA_W'(64);
                    fh = rfce_pkg::CFG_DATA_W'(0);
                end
                PHASES - 1:
                begin
                    fw = rfce_pkg::CFG_DATA_W'(64);
                    fh = rfce_pkg::CFG_DATA_W'(64);
                end
                default:
                begin
                    fw = pick_frame_size();
                    fh = pick_frame_size();
                end
            endcase
            write_register(rfce_pkg::REG_FRAME_WIDTH, fw);
            write_register(rfce_pkg::REG_FRAME_HEIGHT, fh);
            idle_odds = (phase % 3 == 1) ? 0 : $urandom_range(2, 8);
            stall_odds = (phase % 4 == 2) ? 0 : $urandom_range(2, 8);
            repeat (PHASE_ITEMS) send_command(make_random_command());
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
